@@ hdl/assert_macros.svh @@
// assertion macros shared by the flash page log rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/fpcl_pkg.sv @@
// shared constants, types and helpers for the flash page config log
// no dependencies
package fpcl_pkg;

   localparam int WORDS_PER_PAGE = 256;
   localparam int NUM_SLOTS      = 4;

   localparam int IDX_W     = $clog2(WORDS_PER_PAGE);
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ADDR_W    = SLOT_W + IDX_W;
   localparam int MEM_DEPTH = NUM_SLOTS * (2 ** IDX_W);
   localparam int REC_W     = 8;
   localparam int FIELD_W   = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [REC_W-1:0]  rec_type;
   typedef logic [REC_W:0]    word_type;

   // bit 8 set marks an erased word
   localparam word_type ERASED_WORD = {1'b1, {REC_W{1'b0}}};

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef struct packed {
      logic clear;
      logic step;
   } ctr_cmd_type;

   typedef struct packed {
      idx_type idx;
      logic    last;
   } ctr_stat_type;

   function automatic slot_type clamp_slot(input logic [1:0] s);
      slot_type r;
      if (32'(s) >= NUM_SLOTS) begin
         r = SLOT_W'(NUM_SLOTS - 1);
      end else begin
         r = SLOT_W'(s);
      end
      return r;
   endfunction

endpackage

@@ hdl/fpcl_word_ctr.sv @@
// shared word index unit: one counter and end-of-page compare reused by the
// clearing pass, the page scan and the erase sweep; depends on fpcl_pkg
`include "assert_macros.svh"
module fpcl_word_ctr (
   input  logic                   clock,
   input  logic                   reset,
   input  fpcl_pkg::ctr_cmd_type  ctr_cmd,
   output fpcl_pkg::ctr_stat_type ctr_stat
);

   fpcl_pkg::idx_type idx_ff;
   fpcl_pkg::idx_type idx_in;
   logic              last;

   assign last = (idx_ff == fpcl_pkg::IDX_W'(fpcl_pkg::WORDS_PER_PAGE - 1));

   always_comb begin
      priority if (ctr_cmd.clear) begin
         idx_in = '0;
      end else if (ctr_cmd.step) begin
         // wrap at the page end so any page size works
         idx_in = last ? '0 : idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign ctr_stat.idx  = idx_ff;
   assign ctr_stat.last = last;

   `ASSERT_NEXT(a_wrap, clock, reset, ctr_cmd.step && !ctr_cmd.clear && last, idx_ff == '0, "index did not wrap at page end")
   `ASSERT_NEXT(a_clear, clock, reset, ctr_cmd.clear, idx_ff == '0, "index not cleared")
   `ASSERT_NEXT(a_hold, clock, reset, !ctr_cmd.clear && !ctr_cmd.step, $stable(idx_ff), "index moved while idle")

endmodule

@@ hdl/flash_page_config_log.sv @@
// flash page config log: sequencer, page memory and result registers
// depends on fpcl_pkg, fpcl_word_ctr and assert_macros.svh
//
// usage
//   drive req_* and raise start while busy is low; the word is taken at that
//   edge. busy stays high until the access finishes, and the result shows on
//   rsp_* for exactly one cycle with rsp_valid high. the receiver cannot stall.
//   a read returns the latest record of the slot's page (zero if the page is
//   empty or full); a write appends the packed record and returns zero fields.
//   rsp_page_erased flags an access that found its page full and erased it.
// timing
//   the page is scanned one word per cycle through the shared word counter
//   and the single read port of the page memory. rsp_valid and the drop of
//   busy come together once the registered read shows the first erased word.
//   a full page adds an erase sweep over every word of the page. the next
//   word can be taken at the edge that ends the rsp_valid cycle.
// reset
//   reset starts a clearing pass that writes every word of every page erased;
//   busy is high during it.
`include "assert_macros.svh"
module flash_page_config_log (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [1:0] req_slot,
   input  logic [1:0] req_wr_preset,
   input  logic [1:0] req_wr_bank,
   input  logic [1:0] req_wr_preset_prev,
   input  logic [1:0] req_wr_bank_prev,
   output logic       rsp_valid,
   output logic [1:0] rsp_rd_preset,
   output logic [1:0] rsp_rd_bank,
   output logic [1:0] rsp_rd_preset_prev,
   output logic [1:0] rsp_rd_bank_prev,
   output logic       rsp_page_erased
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ERASE
   } state_type;

   state_type                 state_ff;
   fpcl_pkg::slot_type        clr_slot_ff;
   fpcl_pkg::op_type          op_ff;
   fpcl_pkg::slot_type        slot_ff;
   fpcl_pkg::rec_type         wr_rec_ff;
   fpcl_pkg::rec_type         last_rec_ff;
   logic                      rd_vld_ff;
   fpcl_pkg::idx_type         rd_idx_ff;
   fpcl_pkg::word_type        rd_data_ff;
   logic                      rsp_valid_ff;
   fpcl_pkg::rec_type         rsp_rec_ff;
   logic                      rsp_erased_ff;

   fpcl_pkg::word_type        mem [fpcl_pkg::MEM_DEPTH];

   fpcl_pkg::ctr_cmd_type     ctr_cmd;
   fpcl_pkg::ctr_stat_type    ctr_stat;
   logic                      mem_we;
   fpcl_pkg::addr_type        mem_waddr;
   fpcl_pkg::word_type        mem_wdata;
   fpcl_pkg::addr_type        mem_raddr;
   logic                      hit;
   fpcl_pkg::rec_type         fin_rec;
   logic                      accept;

   fpcl_word_ctr u_word_ctr (
      .clock    (clock),
      .reset    (reset),
      .ctr_cmd  (ctr_cmd),
      .ctr_stat (ctr_stat)
   );

   assign accept  = start && (state_ff == ST_IDLE);
   // word fetched last cycle is erased: the scan ends here
   assign hit     = rd_vld_ff && rd_data_ff[fpcl_pkg::REC_W];
   assign fin_rec = (op_ff == fpcl_pkg::OP_WRITE) ? wr_rec_ff : '0;

   always_comb begin
      ctr_cmd   = '0;
      mem_we    = 1'b0;
      mem_waddr = {slot_ff, ctr_stat.idx};
      mem_wdata = fpcl_pkg::ERASED_WORD;
      mem_raddr = {slot_ff, ctr_stat.idx};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = {clr_slot_ff, ctr_stat.idx};
            ctr_cmd.step = 1'b1;
         end
         ST_IDLE: begin
            ctr_cmd.clear = accept;
         end
         ST_SCAN: begin
            if (hit) begin
               mem_we    = (op_ff == fpcl_pkg::OP_WRITE);
               mem_waddr = {slot_ff, rd_idx_ff};
               mem_wdata = {1'b0, wr_rec_ff};
            end else begin
               ctr_cmd.step = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (hit) begin
               mem_we    = (op_ff == fpcl_pkg::OP_WRITE);
               mem_waddr = {slot_ff, rd_idx_ff};
               mem_wdata = {1'b0, wr_rec_ff};
            end else begin
               ctr_cmd.clear = 1'b1;
            end
         end
         ST_ERASE: begin
            // word 0 gets the final record in the same sweep
            mem_we       = 1'b1;
            mem_wdata    = (ctr_stat.idx == '0) ? {1'b0, fin_rec} : fpcl_pkg::ERASED_WORD;
            ctr_cmd.step = 1'b1;
         end
         default: begin
            ctr_cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_slot_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               if (ctr_stat.last) begin
                  if (clr_slot_ff == fpcl_pkg::SLOT_W'(fpcl_pkg::NUM_SLOTS - 1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     clr_slot_ff <= clr_slot_ff + 1'b1;
                  end
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_ff       <= fpcl_pkg::op_type'(req_operation);
                  slot_ff     <= fpcl_pkg::clamp_slot(req_slot);
                  wr_rec_ff   <= {req_wr_bank_prev, req_wr_preset_prev,
                                  req_wr_bank, req_wr_preset};
                  last_rec_ff <= '0;
                  rd_vld_ff   <= 1'b0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_vld_ff <= 1'b1;
               rd_idx_ff <= ctr_stat.idx;
               if (hit) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_erased_ff <= 1'b0;
                  rsp_rec_ff    <= (op_ff == fpcl_pkg::OP_READ) ? last_rec_ff : '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  if (rd_vld_ff) begin
                     last_rec_ff <= rd_data_ff[fpcl_pkg::REC_W-1:0];
                  end
                  if (ctr_stat.last) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (hit) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_erased_ff <= 1'b0;
                  rsp_rec_ff    <= (op_ff == fpcl_pkg::OP_READ) ? last_rec_ff : '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= ST_ERASE;
               end
            end
            ST_ERASE: begin
               if (ctr_stat.last) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_erased_ff <= 1'b1;
                  rsp_rec_ff    <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rd_preset      = rsp_rec_ff[1:0];
   assign rsp_rd_bank        = rsp_rec_ff[3:2];
   assign rsp_rd_preset_prev = rsp_rec_ff[5:4];
   assign rsp_rd_bank_prev   = rsp_rec_ff[7:6];
   assign rsp_page_erased    = rsp_erased_ff;

   `ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy, "no busy after accepted word")
   `ASSERT_ALWAYS(a_rsp_idle, clock, reset, !rsp_valid || !busy, "result shown while busy")
   `ASSERT_ALWAYS(a_erase_zero, clock, reset, !(rsp_valid && rsp_page_erased) || (rsp_rec_ff == '0), "erased page returned nonzero record")
   `ASSERT_NEXT(a_one_rsp, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")

endmodule
